/* rtl/i2cm_pkg.sv */
package i2cm_pkg;

    localparam int MAX_ADDR_BYTES = 4;
    localparam int COUNT_WIDTH    = 16;
    localparam int PHASE_W        = 10;
    localparam int ALEN_W         = 3;

    localparam logic [PHASE_W-1:0] PHASE_LEN_RESET = 10'd5;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_BEGIN  = 2'd1;
    localparam logic [1:0] FUNC_SUPPLY = 2'd2;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FILL1 = 2'd2;
    localparam logic [1:0] OP_FILL0 = 2'd3;

    localparam logic [7:0] FILL_ONES  = 8'hFF;
    localparam logic [7:0] FILL_ZEROS = 8'h00;

    typedef enum logic [16:0] {
        PH_IDLE = 17'b1 << 0,
        PH_ST_A = 17'b1 << 1,
        PH_ST_B = 17'b1 << 2,
        PH_ST_C = 17'b1 << 3,
        PH_TX_A = 17'b1 << 4,
        PH_TX_B = 17'b1 << 5,
        PH_SA_A = 17'b1 << 6,
        PH_SA_B = 17'b1 << 7,
        PH_WAIT = 17'b1 << 8,
        PH_RX_A = 17'b1 << 9,
        PH_RX_B = 17'b1 << 10,
        PH_MA_A = 17'b1 << 11,
        PH_MA_B = 17'b1 << 12,
        PH_RS_A = 17'b1 << 13,
        PH_SP_A = 17'b1 << 14,
        PH_SP_B = 17'b1 << 15,
        PH_SP_C = 17'b1 << 16
    } phase_t;

    typedef enum logic [1:0] {
        STG_DEV_W = 2'd0,
        STG_ADDR  = 2'd1,
        STG_DEV_R = 2'd2,
        STG_DATA  = 2'd3
    } stage_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       write_request;
        logic       nack_seen;
        logic       busy_res;
        logic       done_res;
    } result_t;

endpackage

/* rtl/i2cm_core.sv */
module i2cm_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [i2cm_pkg::PHASE_W-1:0]     cfg_wr_data,
    input  logic                             in_fire,
    input  logic [1:0]                       func,
    input  logic [6:0]                       dev_address,
    input  logic [1:0]                       operation,
    input  logic [31:0]                      mem_address,
    input  logic [i2cm_pkg::ALEN_W-1:0]      addr_len,
    input  logic [i2cm_pkg::COUNT_WIDTH-1:0] byte_count,
    input  logic [7:0]                       write_data,
    input  logic                             sda_in,
    output i2cm_pkg::result_t                res
);
    import i2cm_pkg::*;

    logic [PHASE_W-1:0]     phase_len_reg;
    phase_t                 phase_reg, phase_next;
    stage_t                 stage_reg, stage_next;
    logic [PHASE_W-1:0]     tick_reg, tick_next;
    logic [3:0]             bit_reg, bit_next;
    logic [7:0]             shift_reg, shift_next;
    logic [COUNT_WIDTH-1:0] bytes_reg, bytes_next;
    logic [ALEN_W-1:0]      abytes_reg, abytes_next;
    logic [31:0]            maddr_reg, maddr_next;
    logic [6:0]             dev_reg, dev_next;
    logic [1:0]             op_reg, op_next;
    logic [7:0]             hold_reg, hold_next;
    logic                   full_reg, full_next;
    logic                   nack_reg, nack_next;
    logic                   scl_reg, scl_next;
    logic                   sda_reg, sda_next;
    logic [7:0]             last_reg, last_next;
    logic                   ack_reg, ack_next;
    logic                   valid_now, done_now;

    logic [PHASE_W-1:0]     len_eff;
    logic [PHASE_W-1:0]     tick_inc;
    logic [7:0]             addr_byte;

    assign len_eff  = (phase_len_reg == '0) ? PHASE_W'(1) : phase_len_reg;
    assign tick_inc = tick_reg + PHASE_W'(1);

    // memory address byte picked by the remaining address count, msb first
    always_comb begin
        addr_byte = 8'h00;
        for (int i = 0; i < MAX_ADDR_BYTES; i++) begin
            if (abytes_reg == ALEN_W'(i + 1) && i < 4) begin
                addr_byte = maddr_reg[(i % 4) * 8 +: 8];
            end
        end
    end

    always_comb begin
        phase_t go;
        logic   do_enter;
        logic   do_nd;

        go          = PH_IDLE;
        do_enter    = 1'b0;
        do_nd       = 1'b0;
        phase_next  = phase_reg;
        stage_next  = stage_reg;
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        bytes_next  = bytes_reg;
        abytes_next = abytes_reg;
        maddr_next  = maddr_reg;
        dev_next    = dev_reg;
        op_next     = op_reg;
        hold_next   = hold_reg;
        full_next   = full_reg;
        nack_next   = nack_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        last_next   = last_reg;
        ack_next    = ack_reg;
        valid_now   = 1'b0;
        done_now    = 1'b0;

        if (in_fire) begin
            if (func == FUNC_TICK) begin
                if (phase_reg == PH_WAIT) begin
                    do_nd = full_reg;
                end else if (phase_reg != PH_IDLE) begin
                    tick_next = tick_inc;
                    if (tick_inc >= len_eff) begin
                        do_enter = 1'b1;
                        unique case (phase_reg)
                            PH_ST_A: go = PH_ST_B;
                            PH_ST_B: go = PH_ST_C;
                            PH_ST_C: begin
                                shift_next = {dev_reg, stage_reg == STG_DEV_R};
                                bit_next   = 4'd8;
                                go         = PH_TX_A;
                            end
                            PH_TX_A: go = PH_TX_B;
                            PH_TX_B: begin
                                shift_next = {shift_reg[6:0], 1'b0};
                                bit_next   = (bit_reg != 4'd0) ? bit_reg - 4'd1 : bit_reg;
                                go = (bit_next != 4'd0) ? PH_TX_A : PH_SA_A;
                            end
                            PH_SA_A: go = PH_SA_B;
                            PH_SA_B: begin
                                if (sda_in) nack_next = 1'b1;
                                if (stage_reg == STG_DEV_W || stage_reg == STG_ADDR) begin
                                    if (abytes_reg != '0) begin
                                        shift_next  = addr_byte;
                                        bit_next    = 4'd8;
                                        abytes_next = abytes_reg - ALEN_W'(1);
                                        stage_next  = STG_ADDR;
                                        go          = PH_TX_A;
                                    end else if (op_reg == OP_READ) begin
                                        stage_next = STG_DEV_R;
                                        go         = PH_RS_A;
                                    end else begin
                                        do_enter = 1'b0;
                                        do_nd    = 1'b1;
                                    end
                                end else if (stage_reg == STG_DEV_R) begin
                                    if (bytes_reg != '0) begin
                                        shift_next = 8'h00;
                                        bit_next   = 4'd8;
                                        go         = PH_RX_A;
                                    end else begin
                                        go = PH_SP_A;
                                    end
                                end else begin
                                    do_enter = 1'b0;
                                    do_nd    = 1'b1;
                                end
                            end
                            PH_RX_A: go = PH_RX_B;
                            PH_RX_B: begin
                                shift_next = {shift_reg[6:0], sda_in};
                                bit_next   = (bit_reg != 4'd0) ? bit_reg - 4'd1 : bit_reg;
                                if (bit_next != 4'd0) begin
                                    go = PH_RX_A;
                                end else begin
                                    last_next  = shift_next;
                                    valid_now  = 1'b1;
                                    bytes_next = bytes_reg - COUNT_WIDTH'(1);
                                    ack_next   = (bytes_next == '0);
                                    go         = PH_MA_A;
                                end
                            end
                            PH_MA_A: go = PH_MA_B;
                            PH_MA_B: begin
                                if (bytes_reg != '0) begin
                                    shift_next = 8'h00;
                                    bit_next   = 4'd8;
                                    go         = PH_RX_A;
                                end else begin
                                    go = PH_SP_A;
                                end
                            end
                            PH_RS_A: go = PH_ST_A;
                            PH_SP_A: go = PH_SP_B;
                            PH_SP_B: go = PH_SP_C;
                            PH_SP_C: begin
                                done_now = 1'b1;
                                go       = PH_IDLE;
                            end
                            default: go = PH_IDLE;
                        endcase
                    end
                end
            end else if (func == FUNC_BEGIN) begin
                if (phase_reg == PH_IDLE) begin
                    dev_next    = dev_address;
                    op_next     = operation;
                    maddr_next  = mem_address;
                    abytes_next = (addr_len > ALEN_W'(MAX_ADDR_BYTES)) ?
                                  ALEN_W'(MAX_ADDR_BYTES) : addr_len;
                    bytes_next  = byte_count;
                    full_next   = 1'b0;
                    nack_next   = 1'b0;
                    stage_next  = STG_DEV_W;
                    do_enter    = 1'b1;
                    go          = PH_ST_A;
                end
            end else if (func == FUNC_SUPPLY) begin
                if (!full_reg) begin
                    hold_next = write_data;
                    full_next = 1'b1;
                end
            end
        end

        // fetch of the next data byte, or stop when none are left
        if (do_nd) begin
            do_enter = 1'b1;
            if (bytes_reg == '0) begin
                go = PH_SP_A;
            end else begin
                stage_next = STG_DATA;
                if (op_reg == OP_WRITE) begin
                    if (full_reg) begin
                        full_next  = 1'b0;
                        bytes_next = bytes_reg - COUNT_WIDTH'(1);
                        shift_next = hold_reg;
                        bit_next   = 4'd8;
                        go         = PH_TX_A;
                    end else begin
                        go = PH_WAIT;
                    end
                end else begin
                    bytes_next = bytes_reg - COUNT_WIDTH'(1);
                    shift_next = (op_reg == OP_FILL1) ? FILL_ONES : FILL_ZEROS;
                    bit_next   = 4'd8;
                    go         = PH_TX_A;
                end
            end
        end

        // line levels on phase entry
        if (do_enter) begin
            phase_next = go;
            tick_next  = '0;
            unique case (go)
                PH_ST_A: begin scl_next = 1'b1; sda_next = 1'b1; end
                PH_ST_B: begin scl_next = 1'b1; sda_next = 1'b0; end
                PH_ST_C: begin scl_next = 1'b0; sda_next = 1'b0; end
                PH_TX_A: begin scl_next = 1'b0; sda_next = shift_next[7]; end
                PH_SA_A, PH_WAIT, PH_RX_A, PH_RS_A: begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                end
                PH_MA_A: begin scl_next = 1'b0; sda_next = ack_next; end
                PH_SP_A: begin scl_next = 1'b0; sda_next = 1'b0; end
                PH_SP_B: begin scl_next = 1'b1; sda_next = 1'b0; end
                PH_SP_C: begin scl_next = 1'b1; sda_next = 1'b1; end
                PH_TX_B, PH_SA_B, PH_RX_B, PH_MA_B: scl_next = 1'b1;
                default: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_len_reg <= PHASE_LEN_RESET;
            phase_reg     <= PH_IDLE;
            stage_reg     <= STG_DEV_W;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            bytes_reg     <= '0;
            abytes_reg    <= '0;
            maddr_reg     <= '0;
            dev_reg       <= '0;
            op_reg        <= '0;
            full_reg      <= 1'b0;
            nack_reg      <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            last_reg      <= '0;
            ack_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                phase_len_reg <= cfg_wr_data;
            end
            phase_reg  <= phase_next;
            stage_reg  <= stage_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            bytes_reg  <= bytes_next;
            abytes_reg <= abytes_next;
            maddr_reg  <= maddr_next;
            dev_reg    <= dev_next;
            op_reg     <= op_next;
            full_reg   <= full_next;
            nack_reg   <= nack_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            last_reg   <= last_next;
            ack_reg    <= ack_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
    end

    always_comb begin
        res.scl_level     = scl_next;
        res.sda_level     = sda_next;
        res.read_byte     = last_next;
        res.read_valid    = valid_now;
        res.write_request = (phase_next != PH_IDLE) && (op_next == OP_WRITE) &&
                            !full_next && (bytes_next != '0);
        res.nack_seen     = nack_next;
        res.busy_res      = (phase_next != PH_IDLE);
        res.done_res      = done_now;
    end

endmodule

/* rtl/i2cm_out_stage.sv */
module i2cm_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  i2cm_pkg::result_t  res_in,
    input  logic               m_ready,
    output logic               m_valid,
    output i2cm_pkg::result_t  res_out,
    output logic               can_accept
);
    import i2cm_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // a waiting result is taken in the same cycle a new one lands
    assign can_accept = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_fire) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            data_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = data_reg;

endmodule

/* rtl/i2c_master_register_transfer.sv */
// i2c master for register-addressed transfers, stepped one item at a time
//
// input channel (s_valid/s_ready): each item is a tick (func 0), a begin
// command (func 1) carrying device address, operation, memory address,
// address length and byte count, or a write byte for the holding register
// (func 2). sda_in is the sampled bus level, used on ticks.
// result channel (m_valid/m_ready): exactly one result per input item with
// the driven scl/sda levels, last read byte, status and done flag.
// configuration: cfg_wr_en/cfg_wr_data write the phase length (ticks per
// bus phase); the user must write it only while the block is idle, unchecked.
//
// the state machine updates and the result is registered at the edge
// that accepts the item. one item per cycle is sustained while m_ready
// stays high; the single output register frees as it is drained.
// a stalled receiver holds the result; s_ready stays high as long as the
// output register is empty or being taken in the same cycle.
// reset releases both lines, returns to idle and sets phase length to 5.
module i2c_master_register_transfer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [i2cm_pkg::PHASE_W-1:0]     cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_func,
    input  logic [6:0]                       s_dev_address,
    input  logic [1:0]                       s_operation,
    input  logic [31:0]                      s_mem_address,
    input  logic [i2cm_pkg::ALEN_W-1:0]      s_addr_len,
    input  logic [i2cm_pkg::COUNT_WIDTH-1:0] s_byte_count,
    input  logic [7:0]                       s_write_data,
    input  logic                             s_sda_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_scl_level,
    output logic                             m_sda_level,
    output logic [7:0]                       m_read_byte,
    output logic                             m_read_valid,
    output logic                             m_write_request,
    output logic                             m_nack_seen,
    output logic                             m_busy_res,
    output logic                             m_done_res
);
    import i2cm_pkg::*;

    logic    in_fire;
    result_t core_res;
    result_t out_res;

    assign in_fire = s_valid && s_ready;

    i2cm_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .func        (s_func),
        .dev_address (s_dev_address),
        .operation   (s_operation),
        .mem_address (s_mem_address),
        .addr_len    (s_addr_len),
        .byte_count  (s_byte_count),
        .write_data  (s_write_data),
        .sda_in      (s_sda_in),
        .res         (core_res)
    );

    i2cm_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .res_in     (core_res),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .res_out    (out_res),
        .can_accept (s_ready)
    );

    assign m_scl_level     = out_res.scl_level;
    assign m_sda_level     = out_res.sda_level;
    assign m_read_byte     = out_res.read_byte;
    assign m_read_valid    = out_res.read_valid;
    assign m_write_request = out_res.write_request;
    assign m_nack_seen     = out_res.nack_seen;
    assign m_busy_res      = out_res.busy_res;
    assign m_done_res      = out_res.done_res;

endmodule
